FILE: design/phit_pkg.sv
// Shared types and constants for the pointer handle interning table.
package phit_pkg;

   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 8;
   localparam int CMD_W    = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   // Search token handed from cell to cell along the row
   typedef struct packed {
      logic                live;
      logic                hit;
      logic [HANDLE_W-1:0] pos;
   } tok_type;

   // Broadcast from the control to every cell
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             wr_en;
   } ctrl_type;

endpackage

FILE: design/phit_cell.sv
// One storage cell of the interning row: holds one key and passes the search token on.
module phit_cell import phit_pkg::*; #(
   parameter int CNT_W = 9,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl,
   input  logic [CNT_W-1:0] count,
   input  tok_type          tok_i,
   output tok_type          tok_o
);

   logic [KEY_W-1:0] key_ff;
   tok_type          tok_ff;
   tok_type          tok_in;
   logic             match;

   // Store the key when this cell is the next free slot
   always_ff @(posedge clock) begin
      if (ctrl.wr_en && (count == CNT_W'(INDEX))) begin
         key_ff <= ctrl.key;
      end
   end

   // Match only a filled cell
   assign match = (CNT_W'(INDEX) < count) && (key_ff == ctrl.key);

   // Merge own hit into the passing token; keep an earlier hit
   always_comb begin
      tok_in.live = tok_i.live;
      tok_in.hit  = tok_i.hit | (tok_i.live & match);
      tok_in.pos  = tok_i.hit ? tok_i.pos : HANDLE_W'(INDEX);
   end

   // Advance the token one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

FILE: design/pointer_handle_interning_table.sv
// Top level of the pointer handle interning table: control, entry count and the cell row.
//
//  channel   ports                                        handshake
//  request   req_command, req_pointer_key                 start && !busy
//  response  rsp_handle, rsp_found, rsp_inserted,         rsp_valid, one cycle
//            rsp_table_full
//
// Insert and find: a token walks the row of CAPACITY cells, one cell a cycle,
// and the response strobe is registered once the token leaves the last cell,
// so the row length sets the response time. Clear and the unused command answer in the
// cycle after acceptance. A new word can be accepted in the strobe cycle.
// Synchronous reset empties the table; stored keys need no clearing since
// only cells below the entry count ever match. The receiver cannot stall.
module pointer_handle_interning_table import phit_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [KEY_W-1:0]    req_pointer_key,
   output logic                rsp_valid,
   output logic [HANDLE_W-1:0] rsp_handle,
   output logic                rsp_found,
   output logic                rsp_inserted,
   output logic                rsp_table_full
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic                state_ff, state_in;
   logic                launch_ff, launch_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                valid_ff, valid_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                found_ff, found_in;
   logic                inserted_ff, inserted_in;
   logic                full_ff, full_in;

   logic     accept;
   logic     done;
   logic     room;
   ctrl_type ctrl;
   tok_type  tok_chain [0:CAPACITY];

   assign accept = start && (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_SEARCH) && tok_chain[CAPACITY].live;
   assign room   = count_ff < CNT_W'(CAPACITY);

   // Broadcast key and write enable to the row
   always_comb begin
      ctrl.key   = key_ff;
      ctrl.wr_en = done && !tok_chain[CAPACITY].hit && (cmd_ff == CMD_INSERT) && room;
   end

   // Inject a single token at the head of the row
   always_comb begin
      tok_chain[0].live = launch_ff;
      tok_chain[0].hit  = 1'b0;
      tok_chain[0].pos  = '0;
   end

   // Build the row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      phit_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .count (count_ff),
         .tok_i (tok_chain[i]),
         .tok_o (tok_chain[i+1])
      );
   end

   // Sequence commands and form the response word
   always_comb begin
      state_in    = state_ff;
      launch_in   = 1'b0;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      valid_in    = 1'b0;
      handle_in   = '0;
      found_in    = 1'b0;
      inserted_in = 1'b0;
      full_in     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               key_in = req_pointer_key;
               case (req_command)
                  CMD_INSERT, CMD_FIND: begin
                     launch_in = 1'b1;
                     state_in  = ST_SEARCH;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     valid_in = 1'b1;
                  end
                  default: begin
                     valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (done) begin
               state_in = ST_IDLE;
               valid_in = 1'b1;
               if (tok_chain[CAPACITY].hit) begin
                  handle_in = tok_chain[CAPACITY].pos;
                  found_in  = 1'b1;
               end else if (cmd_ff == CMD_INSERT) begin
                  if (room) begin
                     handle_in   = HANDLE_W'(count_ff);
                     inserted_in = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                  end else begin
                     full_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   // Hold the request and response payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      handle_ff   <= handle_in;
      found_ff    <= found_in;
      inserted_ff <= inserted_in;
      full_ff     <= full_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_handle     = handle_ff;
   assign rsp_found      = found_ff;
   assign rsp_inserted   = inserted_ff;
   assign rsp_table_full = full_ff;

endmodule
